@@ sv/hpd_pkg.sv @@
package hpd_pkg;

  // Angle format: Q(2).ANGLE_FRAC_BITS plus sign
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANG_W           = ANGLE_FRAC_BITS + 3;

  localparam longint PI_Q29  = 64'sd1686629713;
  localparam longint PI_L    = (PI_Q29 + (64'sd1 <<< (28 - ANGLE_FRAC_BITS)))
                               >>> (29 - ANGLE_FRAC_BITS);
  localparam int     ANG_PI  = int'(PI_L);
  localparam int     ANG_2PI = 2 * ANG_PI;

  // Modulo reduction: bias by 2pi*2^(steps-1), then one restoring step per cycle
  localparam int WRAP_STEPS = 5;
  localparam int WRAP_W     = ANGLE_FRAC_BITS + 9;
  localparam int WRAP_BIAS  = ANG_2PI * (2 ** (WRAP_STEPS - 1));

  // Fixed-point rescale amounts
  localparam int RATE_SHIFT  = 26 - ANGLE_FRAC_BITS;
  localparam int PROP_SHIFT  = ANGLE_FRAC_BITS - 4;
  localparam int INTEG_SHIFT = ANGLE_FRAC_BITS + 8;

  // Serial multiplier: signed A times unsigned B, one bit of B per cycle
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int U_W = 42 - ANGLE_FRAC_BITS;

  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_SECONDS    = 3'd0,
    CFG_ALIGN_THRESHOLD = 3'd1,
    CFG_KP_STRAIGHT     = 3'd2,
    CFG_KP_TURN         = 3'd3,
    CFG_KI_GAIN         = 3'd4,
    CFG_MAX_SPEED       = 3'd5,
    CFG_STRAIGHT_SPEED  = 3'd6
  } cfg_idx_t;

endpackage

@@ sv/hpd_in_if.sv @@
interface hpd_in_if;
  import hpd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] gyro_rate;
  logic signed [DATA_W-1:0] target_heading;

  modport source (output valid, gyro_rate, target_heading, input ready);
  modport sink   (input valid, gyro_rate, target_heading, output ready);
endinterface

@@ sv/hpd_out_if.sv @@
interface hpd_out_if;
  import hpd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] left_wheel;
  logic signed [DATA_W-1:0] right_wheel;
  logic signed [DATA_W-1:0] heading;
  logic signed [DATA_W-1:0] heading_error;
  logic                     turn_mode;

  modport source (output valid, left_wheel, right_wheel, heading, heading_error, turn_mode,
                  input ready);
  modport sink   (input valid, left_wheel, right_wheel, heading, heading_error, turn_mode,
                  output ready);
endinterface

@@ sv/hpd_cfg_if.sv @@
interface hpd_cfg_if;
  import hpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/heading_pi_differential_drive_top.sv @@
// Gain-scheduled PI heading controller. Each input transfer carries one yaw-rate
// sample and a target heading and yields one result: left and right wheel speeds,
// the wrapped heading, the wrapped heading error and the turn-mode flag. The result
// register loads after three 16-step shift-add multiplies (rate times period, kp
// times error, ki times error sum), two modulo-2pi reductions and eight further
// steps; the next item is taken in the cycle after the result reaches the output
// register, so the block takes no new item before the last one is through, and
// a stalled output holds the block until the previous result has been taken.
// Configuration writes are accepted in every cycle and must only be issued while
// the block is idle.
module heading_pi_differential_drive_top (
  input  logic      clk,
  input  logic      rst_n,
  hpd_in_if.sink    in_ch,
  hpd_out_if.source out_ch,
  hpd_cfg_if.sink   cfg_ch
);
  import hpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_RATE, S_DELTA, S_HSUM, S_WRAP_INIT, S_WRAP, S_WRAP_DONE,
    S_SUM, S_MUL_P, S_PROP, S_MUL_I, S_INTEG, S_USUM, S_SPEED, S_OUT
  } state_t;

  localparam int K_W = $clog2(WRAP_STEPS);

  localparam logic signed [WRAP_W:0]    PI_W      = (WRAP_W+1)'(ANG_PI);
  localparam logic [WRAP_W-1:0]         MOD_W     = WRAP_W'(ANG_2PI);
  localparam logic signed [WRAP_W:0]    BIAS_W    = (WRAP_W+1)'(WRAP_BIAS);
  localparam logic signed [MUL_P_W-1:0] RATE_HALF = MUL_P_W'(1) << (RATE_SHIFT - 1);
  localparam logic signed [MUL_P_W-1:0] PROP_HALF = MUL_P_W'(1) << (PROP_SHIFT - 1);
  localparam logic signed [MUL_P_W-1:0] INTG_HALF = MUL_P_W'(1) << (INTEG_SHIFT - 1);

  // configuration
  logic [15:0] tick_r;
  logic [14:0] thr_r;
  logic [11:0] kp_s_r;
  logic [11:0] kp_t_r;
  logic [15:0] ki_r;
  logic [14:0] max_r;
  logic [14:0] base_spd_r;

  // control state
  state_t                   state_r;
  logic                     out_valid_r;
  logic                     phase_r;
  logic                     inr_r;
  logic [K_W-1:0]           k_r;
  logic signed [ANG_W-1:0]  heading_acc_r;
  logic signed [ANG_W-1:0]  last_err_r;
  logic signed [31:0]       esum_r;

  // working payload
  logic signed [DATA_W-1:0] tgt_r;
  logic                     turn_r;
  logic signed [WRAP_W:0]   a_r;
  logic [WRAP_W-1:0]        v_r;
  logic signed [ANG_W-1:0]  h_r;
  logic signed [ANG_W-1:0]  err_r;
  logic signed [U_W-1:0]    prop_r;
  logic signed [U_W-1:0]    u_r;
  logic signed [DATA_W-1:0] ls_r;
  logic signed [DATA_W-1:0] rs_r;

  // output register
  logic signed [DATA_W-1:0] o_left_r;
  logic signed [DATA_W-1:0] o_right_r;
  logic signed [DATA_W-1:0] o_head_r;
  logic signed [DATA_W-1:0] o_err_r;
  logic                     o_turn_r;

  // serial multiplier
  logic                       mul_start;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic                       mul_done;
  logic signed [MUL_P_W-1:0]  mul_prod;

  // datapath helpers
  logic                       in_acc;
  logic                       out_free;
  logic                       out_load;
  logic signed [ANG_W-1:0]    mag;
  logic [WRAP_W-1:0]          mod_k;
  logic signed [WRAP_W:0]     v_nxt;
  logic signed [WRAP_W:0]     wrapped;
  logic signed [ANG_W-1:0]    res;
  logic signed [32:0]         esum_nxt;
  logic signed [MUL_P_W-1:0]  rnd_rate;
  logic signed [MUL_P_W-1:0]  rnd_prop;
  logic signed [MUL_P_W-1:0]  rnd_intg;
  logic signed [U_W:0]        base_s;
  logic signed [U_W:0]        lim_s;
  logic signed [U_W:0]        r_sum;
  logic signed [U_W:0]        l_sum;

  function automatic logic signed [DATA_W-1:0] clamp_spd(logic signed [U_W:0] v,
                                                         logic signed [U_W:0] lim);
    logic signed [U_W:0] c;
    c = v;
    if (v > lim) c = lim;
    if (v < -lim) c = -lim;
    return DATA_W'(c);
  endfunction

  hpd_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = (state_r == S_OUT) && out_free;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = MUL_A_W'(in_ch.gyro_rate);
    mul_b     = tick_r;
    case (state_r)
      S_IDLE: mul_start = in_acc;
      S_SUM: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(err_r);
        mul_b     = MUL_B_W'(turn_r ? kp_t_r : kp_s_r);
      end
      S_PROP: begin
        mul_start = 1'b1;
        mul_a     = esum_r;
        mul_b     = ki_r;
      end
      default: ;
    endcase
  end

  assign mag      = last_err_r < 0 ? -last_err_r : last_err_r;
  assign mod_k    = MOD_W << k_r;
  assign v_nxt    = a_r + PI_W + BIAS_W;
  assign wrapped  = $signed({1'b0, v_r}) - PI_W;
  // exactly +-pi stays as it is
  assign res      = inr_r ? a_r[ANG_W-1:0] : wrapped[ANG_W-1:0];
  assign esum_nxt = 33'(esum_r) + 33'(err_r);
  assign rnd_rate = (mul_prod + RATE_HALF) >>> RATE_SHIFT;
  assign rnd_prop = (mul_prod + PROP_HALF) >>> PROP_SHIFT;
  assign rnd_intg = (mul_prod + INTG_HALF) >>> INTEG_SHIFT;
  assign base_s   = turn_r ? '0 : (U_W+1)'($signed({1'b0, base_spd_r}));
  assign lim_s    = (U_W+1)'($signed({1'b0, max_r}));
  assign r_sum    = base_s + (U_W+1)'(u_r);
  assign l_sum    = base_s - (U_W+1)'(u_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      phase_r       <= 1'b0;
      inr_r         <= 1'b0;
      k_r           <= '0;
      heading_acc_r <= '0;
      last_err_r    <= '0;
      esum_r        <= '0;
      tick_r        <= 16'd4194;
      thr_r         <= 15'd819;
      kp_s_r        <= 12'd240;
      kp_t_r        <= 12'd800;
      ki_r          <= 16'd0;
      max_r         <= 15'd2145;
      base_spd_r    <= 15'd2145;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_TICK_SECONDS:    tick_r     <= cfg_ch.data;
          CFG_ALIGN_THRESHOLD: thr_r      <= cfg_ch.data[14:0];
          CFG_KP_STRAIGHT:     kp_s_r     <= cfg_ch.data[11:0];
          CFG_KP_TURN:         kp_t_r     <= cfg_ch.data[11:0];
          CFG_KI_GAIN:         ki_r       <= cfg_ch.data;
          CFG_MAX_SPEED:       max_r      <= cfg_ch.data[14:0];
          CFG_STRAIGHT_SPEED:  base_spd_r <= cfg_ch.data[14:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            tgt_r   <= in_ch.target_heading;
            // gain set comes from the previous tick's error
            turn_r  <= !((ANG_W+1)'(unsigned'(mag)) < (ANG_W+1)'(thr_r));
            phase_r <= 1'b0;
            state_r <= S_MUL_RATE;
          end
        end
        S_MUL_RATE: if (mul_done) state_r <= S_DELTA;
        S_DELTA: begin
          a_r     <= rnd_rate[WRAP_W:0];
          state_r <= S_HSUM;
        end
        S_HSUM: begin
          a_r     <= a_r + (WRAP_W+1)'(heading_acc_r);
          state_r <= S_WRAP_INIT;
        end
        S_WRAP_INIT: begin
          inr_r   <= (a_r <= PI_W) && (a_r >= -PI_W);
          v_r     <= v_nxt[WRAP_W-1:0];
          k_r     <= K_W'(WRAP_STEPS - 1);
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          if (v_r >= mod_k) v_r <= v_r - mod_k;
          k_r <= k_r - 1'b1;
          if (k_r == '0) state_r <= S_WRAP_DONE;
        end
        S_WRAP_DONE: begin
          if (!phase_r) begin
            h_r           <= res;
            heading_acc_r <= res;
            a_r           <= (WRAP_W+1)'(tgt_r) - (WRAP_W+1)'(res);
            phase_r       <= 1'b1;
            state_r       <= S_WRAP_INIT;
          end else begin
            err_r      <= res;
            last_err_r <= res;
            state_r    <= S_SUM;
          end
        end
        S_SUM: begin
          // saturate at the 32-bit limits
          if (esum_nxt[32] != esum_nxt[31]) begin
            esum_r <= esum_nxt[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            esum_r <= esum_nxt[31:0];
          end
          state_r <= S_MUL_P;
        end
        S_MUL_P: if (mul_done) state_r <= S_PROP;
        S_PROP: begin
          prop_r  <= rnd_prop[U_W-1:0];
          state_r <= S_MUL_I;
        end
        S_MUL_I: if (mul_done) state_r <= S_INTEG;
        S_INTEG: begin
          u_r     <= rnd_intg[U_W-1:0];
          state_r <= S_USUM;
        end
        S_USUM: begin
          u_r     <= u_r + prop_r;
          state_r <= S_SPEED;
        end
        S_SPEED: begin
          rs_r    <= clamp_spd(r_sum, lim_s);
          ls_r    <= clamp_spd(l_sum, lim_s);
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            o_left_r  <= ls_r;
            o_right_r <= rs_r;
            o_head_r  <= DATA_W'(h_r);
            o_err_r   <= DATA_W'(err_r);
            o_turn_r  <= turn_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_wheel    = o_left_r;
  assign out_ch.right_wheel   = o_right_r;
  assign out_ch.heading       = o_head_r;
  assign out_ch.heading_error = o_err_r;
  assign out_ch.turn_mode     = o_turn_r;

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result presented without finishing an item");

  a_turn_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_turn_r) |-> (o_left_r == -o_right_r))
    else $error("turn mode speeds are not mirrored");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP_DONE) |-> (res <= ANG_W'(ANG_PI)) && (res >= -ANG_W'(ANG_PI)))
    else $error("wrapped angle outside [-pi, pi]");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL_RATE || state_r == S_MUL_P || state_r == S_MUL_I))
    else $error("multiplier finished outside a wait state");

endmodule

@@ sv/hpd_serial_mul.sv @@
module hpd_serial_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [hpd_pkg::MUL_A_W-1:0] a,
  input  logic        [hpd_pkg::MUL_B_W-1:0] b,
  output logic                               done,
  output logic signed [hpd_pkg::MUL_P_W-1:0] prod
);
  import hpd_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [MUL_A_W:0]   hi_r;
  logic [MUL_B_W-1:0]        lo_r;
  logic signed [MUL_A_W:0]   a_r;
  logic signed [MUL_A_W:0]   hi_sum;

  // add the multiplicand when the low multiplier bit is set
  assign hi_sum = lo_r[0] ? hi_r + a_r : hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        hi_r   <= '0;
        lo_r   <= b;
        a_r    <= (MUL_A_W+1)'(a);
      end else if (busy_r) begin
        hi_r  <= hi_sum >>> 1;
        lo_r  <= {hi_sum[0], lo_r[MUL_B_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r[MUL_A_W-1:0], lo_r};

endmodule
